### rtl/joystick_mode_drive_controller_defines.svh
// ---------------------------------------------------------------------------
// Joystick mode drive controller assertion macros
// Shorthand for clocked implication checks with reset gating.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_MODE_DRIVE_CONTROLLER_DEFINES_SVH
`define JOYSTICK_MODE_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define JMDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JMDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jmdc_pkg.sv
// ---------------------------------------------------------------------------
// Joystick mode drive controller package
// Codes, item types and the axis classifier shared by the controller files.
// ---------------------------------------------------------------------------
package jmdc_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_SELECT = 2'd3
  } mode_t;

  typedef logic [1:0] move_t;
  localparam move_t MOVE_HORIZ  = 2'd0;
  localparam move_t MOVE_VERT   = 2'd1;
  localparam move_t MOVE_SCREEN = 2'd2;

  typedef logic [1:0] event_t;
  localparam event_t EV_NONE = 2'd0;
  localparam event_t EV_SW1  = 2'd1;
  localparam event_t EV_SW2  = 2'd2;
  localparam event_t EV_SW3  = 2'd3;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_NONE      = 3'd0;
  localparam cmd_t CMD_FWD_FAST  = 3'd1;
  localparam cmd_t CMD_FWD_SLOW  = 3'd2;
  localparam cmd_t CMD_BACK_SLOW = 3'd3;
  localparam cmd_t CMD_BACK_FAST = 3'd4;
  localparam cmd_t CMD_STOP      = 3'd5;

  typedef logic [1:0] grip_t;
  localparam grip_t GRIP_NONE  = 2'd0;
  localparam grip_t GRIP_CLOSE = 2'd1;
  localparam grip_t GRIP_OPEN  = 2'd2;
  localparam grip_t GRIP_STOP  = 2'd3;

  typedef logic [1:0] tgt_t;
  localparam tgt_t TGT_NONE = 2'd0;
  localparam tgt_t TGT_GO   = 2'd1;
  localparam tgt_t TGT_SAVE = 2'd2;

  typedef logic [2:0] scr_t;
  localparam scr_t SCR_NONE   = 3'd0;
  localparam scr_t SCR_INTRO  = 3'd1;
  localparam scr_t SCR_MENU   = 3'd2;
  localparam scr_t SCR_UP     = 3'd3;
  localparam scr_t SCR_DOWN   = 3'd4;
  localparam scr_t SCR_SAVING = 3'd5;

  localparam int JOY_W = 14;
  typedef logic [JOY_W-1:0] joy_t;

  localparam joy_t X_HI      = 14'd13500;
  localparam joy_t Y_HI      = 14'd14000;
  localparam joy_t AX_FWD    = 14'd10000;
  localparam joy_t AX_BACK   = 14'd7000;
  localparam joy_t AX_FAST   = 14'd2000;
  localparam joy_t GRIP_CLO  = 14'd9000;
  localparam joy_t GRIP_OPN  = 14'd7000;
  localparam joy_t MENU_UP   = 14'd10000;
  localparam joy_t MENU_DOWN = 14'd5000;

  localparam int CLOSE_DIV = 7500;
  localparam int OPEN_DIV  = 875;
  localparam int SPEED_MAX = 16;

  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_LAST = 2'd3;

  typedef struct packed {
    event_t new_event;
    joy_t   joy_x;
    joy_t   joy_y;
  } item_t;

  typedef struct packed {
    mode_t      mode_now;
    move_t      movement_now;
    cmd_t       cart_x_cmd;
    cmd_t       cart_y_cmd;
    cmd_t       lift_cmd;
    grip_t      grip_cmd;
    logic [4:0] grip_speed;
    slot_t      menu_position;
    tgt_t       target_action;
    scr_t       screen_action;
  } result_t;

  typedef struct packed {
    mode_t  mode;
    move_t  movement;
    event_t pending;
    slot_t  slot;
    logic   latch;
  } state_t;

  function automatic cmd_t classify_axis(input joy_t v, input joy_t hi);
    cmd_t c;
    if (v > hi) begin
      c = CMD_FWD_FAST;
    end else if (v > AX_FWD && v < hi) begin
      c = CMD_FWD_SLOW;
    end else if (v < AX_BACK && v > AX_FAST) begin
      c = CMD_BACK_SLOW;
    end else if (v < AX_FAST) begin
      c = CMD_BACK_FAST;
    end else begin
      c = CMD_STOP;
    end
    return c;
  endfunction

endpackage

### rtl/jmdc_if.sv
// ---------------------------------------------------------------------------
// Joystick mode drive controller channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface jmdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  new_event;
  logic [13:0] joy_x;
  logic [13:0] joy_y;

  modport source (output valid, output new_event, output joy_x, output joy_y, input ready);
  modport sink   (input valid, input new_event, input joy_x, input joy_y, output ready);
  modport mon    (input valid, input new_event, input joy_x, input joy_y, input ready);
endinterface

interface jmdc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_now;
  logic [1:0] movement_now;
  logic [2:0] cart_x_cmd;
  logic [2:0] cart_y_cmd;
  logic [2:0] lift_cmd;
  logic [1:0] grip_cmd;
  logic [4:0] grip_speed;
  logic [1:0] menu_position;
  logic [1:0] target_action;
  logic [2:0] screen_action;

  modport source (
    output valid, output mode_now, output movement_now, output cart_x_cmd,
    output cart_y_cmd, output lift_cmd, output grip_cmd, output grip_speed,
    output menu_position, output target_action, output screen_action,
    input ready
  );
  modport sink (
    input valid, input mode_now, input movement_now, input cart_x_cmd,
    input cart_y_cmd, input lift_cmd, input grip_cmd, input grip_speed,
    input menu_position, input target_action, input screen_action,
    output ready
  );
  modport mon (
    input valid, input mode_now, input movement_now, input cart_x_cmd,
    input cart_y_cmd, input lift_cmd, input grip_cmd, input grip_speed,
    input menu_position, input target_action, input screen_action,
    input ready
  );
endinterface

### rtl/jmdc_grip_speed.sv
// ---------------------------------------------------------------------------
// Gripper speed
// Open/close decision and speed from the first axis by threshold counting.
// ---------------------------------------------------------------------------
module jmdc_grip_speed (
  input  jmdc_pkg::joy_t  joy_x,
  output jmdc_pkg::grip_t grip_cmd,
  output logic [4:0]      grip_speed
);
  import jmdc_pkg::*;

  localparam int NCLOSE = SPEED_MAX - 1;

  joy_t              close_d;
  logic [17:0]       close_d16;
  logic [14:0]       open_x2;
  logic [NCLOSE-1:0] close_hit;
  logic [SPEED_MAX-1:0] open_hit;
  logic [4:0]        close_spd;
  logic [4:0]        open_cnt;

  assign close_d   = joy_x - GRIP_CLO;
  assign close_d16 = {close_d, 4'b0000};
  assign open_x2   = {joy_x, 1'b0};

  // floor(d*16/7500): count multiples of 7500 reached
  always_comb begin
    for (int k = 0; k < NCLOSE; k++) begin
      close_hit[k] = close_d16 >= 18'((k + 1) * CLOSE_DIV);
    end
  end

  // ceil(2g/875): count multiples of 875 exceeded
  always_comb begin
    for (int k = 0; k < SPEED_MAX; k++) begin
      open_hit[k] = open_x2 > 15'(k * OPEN_DIV);
    end
  end

  assign close_spd = 5'($countones(close_hit));
  assign open_cnt  = 5'($countones(open_hit));

  always_comb begin
    if (joy_x > GRIP_CLO) begin
      grip_cmd   = GRIP_CLOSE;
      grip_speed = close_spd;
    end else if (joy_x < GRIP_OPN) begin
      grip_cmd   = GRIP_OPEN;
      grip_speed = 5'(SPEED_MAX) - open_cnt;
    end else begin
      grip_cmd   = GRIP_STOP;
      grip_speed = 5'd0;
    end
  end

endmodule

### rtl/jmdc_step.sv
// ---------------------------------------------------------------------------
// Controller step
// Mode machine then movement machine for one tick; next state and result.
// ---------------------------------------------------------------------------
module jmdc_step (
  input  jmdc_pkg::state_t  state_cur,
  input  jmdc_pkg::item_t   item,
  output jmdc_pkg::state_t  state_nxt,
  output jmdc_pkg::result_t res
);
  import jmdc_pkg::*;

  grip_t      grip_code;
  logic [4:0] grip_spd;

  jmdc_grip_speed u_grip (
    .joy_x      (item.joy_x),
    .grip_cmd   (grip_code),
    .grip_speed (grip_spd)
  );

  always_comb begin
    state_nxt = state_cur;
    res       = '0;

    if (item.new_event != EV_NONE) begin
      state_nxt.pending = item.new_event;
    end

    if (state_cur.movement != 2'd3) begin
      // mode machine
      unique case (state_cur.mode)
        MODE_INIT: begin
          if (state_nxt.pending == EV_SW1) begin
            state_nxt.pending  = EV_NONE;
            state_nxt.mode     = MODE_MANUAL;
            state_nxt.movement = MOVE_HORIZ;
          end
        end
        MODE_MANUAL: begin
          if (state_nxt.pending == EV_SW1 || state_nxt.pending == EV_SW2) begin
            state_nxt.mode     = (state_nxt.pending == EV_SW1) ? MODE_AUTO : MODE_SELECT;
            state_nxt.pending  = EV_NONE;
            state_nxt.movement = MOVE_SCREEN;
            res.cart_x_cmd     = CMD_STOP;
            res.cart_y_cmd     = CMD_STOP;
            res.lift_cmd       = CMD_STOP;
            res.grip_cmd       = GRIP_STOP;
            res.screen_action  = SCR_MENU;
          end
        end
        MODE_AUTO: begin
          if (state_nxt.pending == EV_SW1) begin
            state_nxt.pending  = EV_NONE;
            state_nxt.mode     = MODE_MANUAL;
            state_nxt.movement = MOVE_HORIZ;
            res.screen_action  = SCR_INTRO;
          end else if (state_nxt.pending == EV_SW2) begin
            state_nxt.pending  = EV_NONE;
            res.target_action  = TGT_GO;
          end
        end
        MODE_SELECT: begin
          if (state_nxt.pending == EV_SW1) begin
            state_nxt.pending  = EV_NONE;
            state_nxt.mode     = MODE_MANUAL;
            state_nxt.movement = MOVE_HORIZ;
            res.screen_action  = SCR_INTRO;
          end else if (state_nxt.pending == EV_SW2) begin
            state_nxt.pending  = EV_NONE;
            res.target_action  = TGT_SAVE;
            res.screen_action  = SCR_SAVING;
          end
        end
        default: begin
        end
      endcase

      // movement machine, in the possibly new movement
      case (state_nxt.movement)
        MOVE_HORIZ: begin
          if (state_nxt.pending == EV_SW3) begin
            state_nxt.pending  = EV_NONE;
            state_nxt.movement = MOVE_VERT;
            res.cart_x_cmd     = CMD_STOP;
            res.cart_y_cmd     = CMD_STOP;
          end else begin
            res.cart_x_cmd = classify_axis(item.joy_x, X_HI);
            res.cart_y_cmd = classify_axis(item.joy_y, Y_HI);
          end
        end
        MOVE_VERT: begin
          if (state_nxt.pending == EV_SW3) begin
            state_nxt.pending  = EV_NONE;
            state_nxt.movement = MOVE_HORIZ;
            res.lift_cmd       = CMD_STOP;
            res.grip_cmd       = GRIP_STOP;
            res.grip_speed     = 5'd0;
          end else begin
            res.lift_cmd   = classify_axis(item.joy_y, Y_HI);
            res.grip_cmd   = grip_code;
            res.grip_speed = grip_spd;
          end
        end
        default: begin
          if (item.joy_y > MENU_UP) begin
            if (!state_cur.latch) begin
              res.screen_action = SCR_UP;
              if (state_cur.slot != '0) begin
                state_nxt.slot = state_cur.slot - 2'd1;
              end
            end
            state_nxt.latch = 1'b1;
          end else if (item.joy_y < MENU_DOWN) begin
            if (!state_cur.latch) begin
              res.screen_action = SCR_DOWN;
              if (state_cur.slot != SLOT_LAST) begin
                state_nxt.slot = state_cur.slot + 2'd1;
              end
            end
            state_nxt.latch = 1'b1;
          end else begin
            state_nxt.latch = 1'b0;
          end
        end
      endcase
    end

    res.mode_now      = state_nxt.mode;
    res.movement_now  = state_nxt.movement;
    res.menu_position = state_nxt.slot;
  end

endmodule

### rtl/joystick_mode_drive_controller.sv
// An accepted item waits in the input register; its result loads into the
// result register and shows on the out ports once that register is empty or taken.
// Throughput: one item per cycle while the out channel is not stalled; the tick
// logic sits between the input register and the result register, and the
// controller state updates as the result register loads.
// Reset (rst_n low, synchronous): both stages empty, init mode, screen movement,
// no pending event, menu slot 0, menu latch released.
// ---------------------------------------------------------------------------
// Joystick mode drive controller
// Input register, one-tick controller step and result register.
// ---------------------------------------------------------------------------
module joystick_mode_drive_controller (
  input logic        clk,
  input logic        rst_n,
  jmdc_in_if.sink    in_chan,
  jmdc_out_if.source out_chan
);
  import jmdc_pkg::*;

  localparam state_t STATE_RESET = '{
    mode:     MODE_INIT,
    movement: MOVE_SCREEN,
    pending:  EV_NONE,
    slot:     2'd0,
    latch:    1'b0
  };

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  logic    advance;
  logic    in_take;

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  jmdc_step u_step (
    .state_cur (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.new_event <= in_chan.new_event;
      in_item_r.joy_x     <= in_chan.joy_x;
      in_item_r.joy_y     <= in_chan.joy_y;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.mode_now      = out_res_r.mode_now;
  assign out_chan.movement_now  = out_res_r.movement_now;
  assign out_chan.cart_x_cmd    = out_res_r.cart_x_cmd;
  assign out_chan.cart_y_cmd    = out_res_r.cart_y_cmd;
  assign out_chan.lift_cmd      = out_res_r.lift_cmd;
  assign out_chan.grip_cmd      = out_res_r.grip_cmd;
  assign out_chan.grip_speed    = out_res_r.grip_speed;
  assign out_chan.menu_position = out_res_r.menu_position;
  assign out_chan.target_action = out_res_r.target_action;
  assign out_chan.screen_action = out_res_r.screen_action;

endmodule

### rtl/jmdc_chk.sv
// ---------------------------------------------------------------------------
// Joystick mode drive controller port checks
// Result and input channel properties seen at the top level ports, bound to the top.
// ---------------------------------------------------------------------------
`include "joystick_mode_drive_controller_defines.svh"

module jmdc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] mode_now,
  input logic [1:0] movement_now,
  input logic [1:0] grip_cmd,
  input logic [4:0] grip_speed,
  input logic [1:0] menu_position,
  input logic [1:0] target_action
);
  import jmdc_pkg::*;

  logic manual_now;
  logic screen_now;

  assign manual_now = mode_now == MODE_MANUAL;
  assign screen_now = movement_now == MOVE_SCREEN;

  `JMDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(menu_position) && $stable(grip_speed), "result changed while stalled")
  `JMDC_ASSERT_IMPL(a_mode_move, out_valid, manual_now != screen_now, "movement does not match mode")
  `JMDC_ASSERT_IMPL(a_speed_grip, out_valid && grip_speed != 5'd0, grip_cmd == GRIP_CLOSE || grip_cmd == GRIP_OPEN, "speed without gripper call")
  `JMDC_ASSERT_IMPL(a_target_mode, out_valid && target_action == TGT_SAVE, mode_now == MODE_SELECT, "save outside select mode")
  `JMDC_ASSERT_IMPL(a_in_ready, !out_valid, in_ready, "input stalled with empty result stage")

endmodule

bind joystick_mode_drive_controller jmdc_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .mode_now      (out_chan.mode_now),
  .movement_now  (out_chan.movement_now),
  .grip_cmd      (out_chan.grip_cmd),
  .grip_speed    (out_chan.grip_speed),
  .menu_position (out_chan.menu_position),
  .target_action (out_chan.target_action)
);
